// ----- rtl/hsvle_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the HSV to LED pulse encoder.
// No dependencies; every other file in this folder refers to it by scoped name.
package hsvle_pkg;

   localparam int HUE_W          = 9;
   localparam int CHAN_W         = 8;
   localparam int TICK_W         = 15;
   localparam int WORD_W         = 16;
   localparam int SCALE_W        = 16;
   localparam int BASE_W         = 16;
   localparam int HUE_WRAP       = 360;
   localparam int SECTOR_DEG     = 60;
   localparam int CHAN_MAX       = 255;
   localparam int WORDS_PER_LED  = 24;
   localparam int RGB_W          = 3 * CHAN_W;
   localparam int QUEUE_DEPTH    = 2;
   localparam int CSR_INDEX_W    = 1;

   localparam logic [WORD_W-1:0] MARK_BIT        = 16'h8000;
   localparam logic [TICK_W-1:0] ONE_HIGH_RESET  = 15'd13;
   localparam logic [TICK_W-1:0] ZERO_HIGH_RESET = 15'd5;

   localparam int SAT_FULL_SCALE_DEF = 255;
   localparam int VAL_FULL_SCALE_DEF = 255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ONE_HIGH  = 1'b0,
      CSR_ZERO_HIGH = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      SECT_0 = 3'd0,
      SECT_1 = 3'd1,
      SECT_2 = 3'd2,
      SECT_3 = 3'd3,
      SECT_4 = 3'd4,
      SECT_5 = 3'd5
   } sector_type;

   typedef enum logic [1:0] {
      CHAN_G = 2'd0,
      CHAN_R = 2'd1,
      CHAN_B = 2'd2
   } chan_type;

   typedef struct packed {
      logic [TICK_W-1:0] one_ticks;
      logic [TICK_W-1:0] zero_ticks;
   } ticks_cfg_type;

endpackage

// ----- rtl/hsvle_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts a colour, clamps it, finds the hue sector and forms the
// green, red and blue numerators over three register stages. Uses hsvle_pkg.
module hsvle_front #(
   parameter int SAT_FULL_SCALE = hsvle_pkg::SAT_FULL_SCALE_DEF,
   parameter int VAL_FULL_SCALE = hsvle_pkg::VAL_FULL_SCALE_DEF,
   parameter int KW = $clog2(SAT_FULL_SCALE * hsvle_pkg::SECTOR_DEG + 1),
   parameter int NW = hsvle_pkg::BASE_W + KW
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [hsvle_pkg::HUE_W-1:0]   req_hue,
   input  logic [hsvle_pkg::CHAN_W-1:0]  req_saturation,
   input  logic [hsvle_pkg::CHAN_W-1:0]  req_brightness,
   output logic                          num_valid,
   input  logic                          num_ready,
   output logic [NW-1:0]                 num_g,
   output logic [NW-1:0]                 num_r,
   output logic [NW-1:0]                 num_b
);

   localparam logic [hsvle_pkg::SCALE_W-1:0] SAT16 = hsvle_pkg::SCALE_W'(SAT_FULL_SCALE);
   localparam logic [hsvle_pkg::SCALE_W-1:0] VAL16 = hsvle_pkg::SCALE_W'(VAL_FULL_SCALE);
   localparam logic [KW-1:0] S60 = KW'(SAT_FULL_SCALE * hsvle_pkg::SECTOR_DEG);
   localparam logic [hsvle_pkg::HUE_W-1:0] DEG = hsvle_pkg::HUE_W'(hsvle_pkg::SECTOR_DEG);

   logic adv1, adv2, adv3, accept;
   logic st1_v_ff, st1_v_in, st2_v_ff, st2_v_in, st3_v_ff, st3_v_in;

   // stage 1: clamped colour
   logic [hsvle_pkg::HUE_W-1:0]  h1_ff, h1_in;
   logic [hsvle_pkg::CHAN_W-1:0] s1_ff, s1_in, v1_ff, v1_in;

   // stage 2: sector, base and the three channel factors
   hsvle_pkg::sector_type sect2_ff, sect2_in;
   logic [hsvle_pkg::BASE_W-1:0] base2_ff, base2_in;
   logic [KW-1:0] kx2_ff, kx2_in, ky2_ff, ky2_in, kz2_ff, kz2_in;
   logic [5:0]    frac;
   logic [13:0]   sf, sg;
   logic [hsvle_pkg::SCALE_W-1:0] sdiff;

   // stage 3: numerators in channel order
   logic [NW-1:0] g3_ff, g3_in, r3_ff, r3_in, b3_ff, b3_in;
   logic [NW-1:0] nv, nx, ny, nz;

   always_comb begin
      adv3   = !st3_v_ff || num_ready;
      adv2   = !st2_v_ff || adv3;
      adv1   = !st1_v_ff || adv2;
      busy   = !adv1;
      accept = start && adv1;

      st1_v_in = adv1 ? accept   : st1_v_ff;
      st2_v_in = adv2 ? st1_v_ff : st2_v_ff;
      st3_v_in = adv3 ? st2_v_ff : st3_v_ff;

      // stage 1: clamp; a hue of 360 or more wraps to 0
      h1_in = h1_ff;
      s1_in = s1_ff;
      v1_in = v1_ff;
      if (accept) begin
         h1_in = (req_hue >= hsvle_pkg::HUE_W'(hsvle_pkg::HUE_WRAP)) ? '0 : req_hue;
         s1_in = (hsvle_pkg::SCALE_W'(req_saturation) > SAT16) ?
                 SAT16[hsvle_pkg::CHAN_W-1:0] : req_saturation;
         v1_in = (hsvle_pkg::SCALE_W'(req_brightness) > VAL16) ?
                 VAL16[hsvle_pkg::CHAN_W-1:0] : req_brightness;
      end

      // stage 2
      priority if (h1_ff < DEG) begin
         sect2_in = hsvle_pkg::SECT_0;
         frac     = 6'(h1_ff);
      end else if (h1_ff < 9'(2 * hsvle_pkg::SECTOR_DEG)) begin
         sect2_in = hsvle_pkg::SECT_1;
         frac     = 6'(h1_ff - 9'(1 * hsvle_pkg::SECTOR_DEG));
      end else if (h1_ff < 9'(3 * hsvle_pkg::SECTOR_DEG)) begin
         sect2_in = hsvle_pkg::SECT_2;
         frac     = 6'(h1_ff - 9'(2 * hsvle_pkg::SECTOR_DEG));
      end else if (h1_ff < 9'(4 * hsvle_pkg::SECTOR_DEG)) begin
         sect2_in = hsvle_pkg::SECT_3;
         frac     = 6'(h1_ff - 9'(3 * hsvle_pkg::SECTOR_DEG));
      end else if (h1_ff < 9'(5 * hsvle_pkg::SECTOR_DEG)) begin
         sect2_in = hsvle_pkg::SECT_4;
         frac     = 6'(h1_ff - 9'(4 * hsvle_pkg::SECTOR_DEG));
      end else begin
         sect2_in = hsvle_pkg::SECT_5;
         frac     = 6'(h1_ff - 9'(5 * hsvle_pkg::SECTOR_DEG));
      end
      sf       = 14'(14'(s1_ff) * 14'(frac));
      sg       = 14'(14'(s1_ff) * 14'(6'(hsvle_pkg::SECTOR_DEG) - frac));
      sdiff    = SAT16 - hsvle_pkg::SCALE_W'(s1_ff);
      base2_in = hsvle_pkg::BASE_W'({v1_ff, 8'b0} - {8'b0, v1_ff});
      kx2_in   = KW'(32'(sdiff) * 32'(hsvle_pkg::SECTOR_DEG));
      ky2_in   = S60 - KW'(sf);
      kz2_in   = S60 - KW'(sg);

      // stage 3
      nv = NW'(base2_ff) * NW'(S60);
      nx = NW'(base2_ff) * NW'(kx2_ff);
      ny = NW'(base2_ff) * NW'(ky2_ff);
      nz = NW'(base2_ff) * NW'(kz2_ff);
      unique case (sect2_ff)
         hsvle_pkg::SECT_0: begin r3_in = nv; g3_in = nz; b3_in = nx; end
         hsvle_pkg::SECT_1: begin r3_in = ny; g3_in = nv; b3_in = nx; end
         hsvle_pkg::SECT_2: begin r3_in = nx; g3_in = nv; b3_in = nz; end
         hsvle_pkg::SECT_3: begin r3_in = nx; g3_in = ny; b3_in = nv; end
         hsvle_pkg::SECT_4: begin r3_in = nz; g3_in = nx; b3_in = nv; end
         default: begin           r3_in = nv; g3_in = nx; b3_in = ny; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_v_ff <= 1'b0;
         st2_v_ff <= 1'b0;
         st3_v_ff <= 1'b0;
      end else begin
         st1_v_ff <= st1_v_in;
         st2_v_ff <= st2_v_in;
         st3_v_ff <= st3_v_in;
      end
   end

   always_ff @(posedge clock) begin
      h1_ff <= h1_in;
      s1_ff <= s1_in;
      v1_ff <= v1_in;
      if (adv2) begin
         sect2_ff <= sect2_in;
         base2_ff <= base2_in;
         kx2_ff   <= kx2_in;
         ky2_ff   <= ky2_in;
         kz2_ff   <= kz2_in;
      end
      if (adv3) begin
         g3_ff <= g3_in;
         r3_ff <= r3_in;
         b3_ff <= b3_in;
      end
   end

   assign num_valid = st3_v_ff;
   assign num_g     = g3_ff;
   assign num_r     = r3_ff;
   assign num_b     = b3_ff;

endmodule

// ----- rtl/hsvle_div.sv -----
`timescale 1ns / 1ps
// Shared channel divider: each numerator is divided by the constant full-scale
// denominator through a reciprocal multiplication split into a low and a high half,
// green then red then blue, one colour at a time. Uses hsvle_pkg.
module hsvle_div #(
   parameter int SAT_FULL_SCALE = hsvle_pkg::SAT_FULL_SCALE_DEF,
   parameter int VAL_FULL_SCALE = hsvle_pkg::VAL_FULL_SCALE_DEF,
   parameter int NW = hsvle_pkg::BASE_W + $clog2(SAT_FULL_SCALE * hsvle_pkg::SECTOR_DEG + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [NW-1:0]                num_g,
   input  logic [NW-1:0]                num_r,
   input  logic [NW-1:0]                num_b,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [hsvle_pkg::RGB_W-1:0]  out_rgb
);

   localparam logic [63:0] DEN = 64'(VAL_FULL_SCALE) * 64'(SAT_FULL_SCALE) *
                                 64'(hsvle_pkg::SECTOR_DEG);
   localparam int DW = $clog2(DEN + 64'd1);
   // 2**SH covers 256 * DEN * DEN, so the truncated product is the exact quotient
   // for every numerator up to 255 * DEN
   localparam int SH = hsvle_pkg::CHAN_W + 2 * DW;
   localparam int MW = SH - DW + 2;
   localparam int LW = MW / 2;
   localparam int PW = NW + MW;
   localparam int QW = (PW - SH > hsvle_pkg::CHAN_W) ? PW - SH : hsvle_pkg::CHAN_W;

   function automatic logic [MW-1:0] recip_of(input logic [63:0] den, input int sh);
      logic [127:0] scaled;
      scaled = (128'd1 << sh) + 128'(den) - 128'd1;
      return MW'(scaled / 128'(den));
   endfunction

   localparam logic [MW-1:0]    RECIP    = recip_of(DEN, SH);
   localparam logic [LW-1:0]    RECIP_LO = RECIP[LW-1:0];
   localparam logic [MW-LW-1:0] RECIP_HI = RECIP[MW-1:LW];

   logic active_ff, active_in;
   logic phase_ff, phase_in;
   hsvle_pkg::chan_type chan_ff, chan_in;
   logic [NW-1:0] ng_ff, nr_ff, nb_ff;
   logic [NW-1:0] num_sel;
   logic [PW-1:0] plo_ff, prod_lo, prod_hi, prod;
   logic [QW-1:0] quo;
   logic [hsvle_pkg::CHAN_W-1:0] chan_q;
   logic [hsvle_pkg::RGB_W-hsvle_pkg::CHAN_W-1:0] q_ff;
   logic last, done, step, load;

   always_comb begin
      last      = active_ff && phase_ff && (chan_ff == hsvle_pkg::CHAN_B);
      out_valid = last;
      done      = out_valid && out_ready;
      // hold the final channel while the queue is full
      step      = active_ff && (!last || out_ready);
      in_ready  = !active_ff || done;
      load      = in_valid && in_ready;

      unique case (chan_ff)
         hsvle_pkg::CHAN_G: num_sel = ng_ff;
         hsvle_pkg::CHAN_R: num_sel = nr_ff;
         hsvle_pkg::CHAN_B: num_sel = nb_ff;
         default:           num_sel = '0;
      endcase

      // low half of the reciprocal in the first phase, high half in the second
      prod_lo = PW'(num_sel) * PW'(RECIP_LO);
      prod_hi = PW'(num_sel) * PW'(RECIP_HI);
      prod    = plo_ff + (prod_hi << LW);
      quo     = QW'(prod >> SH);
      chan_q  = (quo > QW'(hsvle_pkg::CHAN_MAX)) ?
                hsvle_pkg::CHAN_W'(hsvle_pkg::CHAN_MAX) : quo[hsvle_pkg::CHAN_W-1:0];
      out_rgb = {q_ff, chan_q};

      active_in = active_ff;
      chan_in   = chan_ff;
      phase_in  = phase_ff;
      if (load) begin
         active_in = 1'b1;
         chan_in   = hsvle_pkg::CHAN_G;
         phase_in  = 1'b0;
      end else if (done) begin
         active_in = 1'b0;
      end else if (step) begin
         phase_in = !phase_ff;
         if (phase_ff) begin
            chan_in = hsvle_pkg::chan_type'(chan_ff + 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         chan_ff   <= hsvle_pkg::CHAN_G;
         phase_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         chan_ff   <= chan_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ng_ff <= num_g;
         nr_ff <= num_r;
         nb_ff <= num_b;
      end
      if (step && !phase_ff) begin
         plo_ff <= prod_lo;
      end
      if (step && phase_ff && !last) begin
         q_ff <= {q_ff[hsvle_pkg::CHAN_W-1:0], chan_q};
      end
   end

endmodule

// ----- rtl/hsvle_queue.sv -----
`timescale 1ns / 1ps
// Short queue of finished colours between the divider and the serialiser.
// Depth from hsvle_pkg.
module hsvle_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   output logic                         push_ready,
   input  logic [hsvle_pkg::RGB_W-1:0]  push_data,
   output logic                         pop_valid,
   input  logic                         pop,
   output logic [hsvle_pkg::RGB_W-1:0]  pop_data
);

   localparam int DEPTH = hsvle_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   logic [hsvle_pkg::RGB_W-1:0] entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   always_comb begin
      push_ready = count_ff != CW'(DEPTH);
      pop_valid  = count_ff != '0;
      pop_data   = entry_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop && pop_valid;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/hsvle_serial.sv -----
`timescale 1ns / 1ps
// Back end: turns each 24-bit colour into 24 pulse words, one per cycle,
// most significant bit first. Uses hsvle_pkg.
module hsvle_serial (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rgb_valid,
   output logic                          rgb_pop,
   input  logic [hsvle_pkg::RGB_W-1:0]   rgb_data,
   input  hsvle_pkg::ticks_cfg_type      ticks_cfg,
   output logic                          rsp_valid,
   output logic [hsvle_pkg::WORD_W-1:0]  rsp_pulse_word,
   output logic                          rsp_last_of_led
);

   localparam int CNT_W = $clog2(hsvle_pkg::WORDS_PER_LED);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(hsvle_pkg::WORDS_PER_LED - 1);

   logic active_ff, active_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [hsvle_pkg::RGB_W-1:0] sh_ff, sh_in;
   logic valid_ff, valid_in, last_ff, last_in;
   logic [hsvle_pkg::WORD_W-1:0] word_ff, word_in;
   logic at_end;
   logic [hsvle_pkg::TICK_W-1:0] ticks;

   always_comb begin
      at_end  = active_ff && (cnt_ff == CNT_LAST);
      rgb_pop = rgb_valid && (!active_ff || at_end);
      ticks   = sh_ff[hsvle_pkg::RGB_W-1] ? ticks_cfg.one_ticks : ticks_cfg.zero_ticks;

      valid_in = active_ff;
      last_in  = at_end;
      word_in  = hsvle_pkg::MARK_BIT | hsvle_pkg::WORD_W'(ticks);

      active_in = active_ff;
      cnt_in    = cnt_ff + CNT_W'(1);
      sh_in     = {sh_ff[hsvle_pkg::RGB_W-2:0], 1'b0};
      // take the next colour while idle or in the cycle the last word is formed
      if (rgb_pop) begin
         active_in = 1'b1;
         cnt_in    = '0;
         sh_in     = rgb_data;
      end else if (at_end) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
         valid_ff  <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         valid_ff  <= valid_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff   <= sh_in;
      word_ff <= word_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pulse_word  = word_ff;
   assign rsp_last_of_led = last_ff;

endmodule

// ----- rtl/hsv_to_led_pulse_encoder.sv -----
`timescale 1ns / 1ps
// HSV to LED pulse encoder, top level: front pipeline, divider, queue,
// serialiser and the two tick registers. Uses hsvle_pkg and the hsvle_* modules.
//
// A colour (hue 0..359, 360 or more wraps to 0; saturation, brightness) is
// taken when start is high and busy is low. Three register stages clamp it and
// form the channel numerators; a shared divider turns each numerator into an
// 8-bit channel by multiplying with the reciprocal of the constant denominator
// in a low and a high half, green, red and blue; a two-entry queue hands the
// result to the serialiser, which drives 24 pulse words on consecutive cycles,
// each marked by rsp_valid for one cycle, the 24th with rsp_last_of_led. The
// receiver cannot stall: every word is lost if not taken when shown. A colour
// passes the front stages, divider, queue and serialiser registers before its
// first word shows; the one word per cycle output sets the steady colour rate.
// Tick registers may only be written while idle.
module hsv_to_led_pulse_encoder #(
   parameter int SAT_FULL_SCALE = hsvle_pkg::SAT_FULL_SCALE_DEF,
   parameter int VAL_FULL_SCALE = hsvle_pkg::VAL_FULL_SCALE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [hsvle_pkg::HUE_W-1:0]         req_hue,
   input  logic [hsvle_pkg::CHAN_W-1:0]        req_saturation,
   input  logic [hsvle_pkg::CHAN_W-1:0]        req_brightness,
   output logic                                rsp_valid,
   output logic [hsvle_pkg::WORD_W-1:0]        rsp_pulse_word,
   output logic                                rsp_last_of_led,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hsvle_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hsvle_pkg::TICK_W-1:0]        csr_wdata
);

   localparam int KW = $clog2(SAT_FULL_SCALE * hsvle_pkg::SECTOR_DEG + 1);
   localparam int NW = hsvle_pkg::BASE_W + KW;

   logic [hsvle_pkg::TICK_W-1:0] one_ff, one_in, zero_ff, zero_in;
   hsvle_pkg::ticks_cfg_type ticks_cfg;

   logic num_valid, num_ready;
   logic [NW-1:0] num_g, num_r, num_b;
   logic div_valid, div_ready;
   logic [hsvle_pkg::RGB_W-1:0] div_rgb, q_rgb;
   logic q_valid, q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      one_in  = one_ff;
      zero_in = zero_ff;
      if (csr_valid) begin
         unique case (hsvle_pkg::csr_index_type'(csr_index))
            hsvle_pkg::CSR_ONE_HIGH:  one_in  = csr_wdata;
            hsvle_pkg::CSR_ZERO_HIGH: zero_in = csr_wdata;
            default: ;
         endcase
      end
      ticks_cfg.one_ticks  = one_ff;
      ticks_cfg.zero_ticks = zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_ff  <= hsvle_pkg::ONE_HIGH_RESET;
         zero_ff <= hsvle_pkg::ZERO_HIGH_RESET;
      end else begin
         one_ff  <= one_in;
         zero_ff <= zero_in;
      end
   end

   hsvle_front #(
      .SAT_FULL_SCALE (SAT_FULL_SCALE),
      .VAL_FULL_SCALE (VAL_FULL_SCALE),
      .KW             (KW),
      .NW             (NW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .num_valid      (num_valid),
      .num_ready      (num_ready),
      .num_g          (num_g),
      .num_r          (num_r),
      .num_b          (num_b)
   );

   hsvle_div #(
      .SAT_FULL_SCALE (SAT_FULL_SCALE),
      .VAL_FULL_SCALE (VAL_FULL_SCALE),
      .NW             (NW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (num_valid),
      .in_ready  (num_ready),
      .num_g     (num_g),
      .num_r     (num_r),
      .num_b     (num_b),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_rgb   (div_rgb)
   );

   hsvle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (div_valid),
      .push_ready (div_ready),
      .push_data  (div_rgb),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_rgb)
   );

   hsvle_serial u_serial (
      .clock           (clock),
      .reset           (reset),
      .rgb_valid       (q_valid),
      .rgb_pop         (q_pop),
      .rgb_data        (q_rgb),
      .ticks_cfg       (ticks_cfg),
      .rsp_valid       (rsp_valid),
      .rsp_pulse_word  (rsp_pulse_word),
      .rsp_last_of_led (rsp_last_of_led)
   );

endmodule

// ----- rtl/hsvle_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the HSV to LED pulse encoder, and the bind that
// attaches them to the top level. Uses hsvle_pkg for widths.
module hsvle_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [hsvle_pkg::WORD_W-1:0]  rsp_pulse_word,
   input logic                          rsp_last_of_led
);

   // a marked last word only comes with a valid transaction
   a_last_has_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_led |-> rsp_valid)
      else $error("last_of_led without rsp_valid");

   a_mark_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pulse_word[hsvle_pkg::WORD_W-1])
      else $error("pulse word without mark bit");

   // an LED is 24 unbroken words: the first one is valid and not a last word
   a_led_span: assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_led |-> ($past(rsp_valid, hsvle_pkg::WORDS_PER_LED - 1) &&
                           !$past(rsp_last_of_led, hsvle_pkg::WORDS_PER_LED - 1)))
      else $error("LED word run not 24 long");

   a_idle_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !busy)
      else $error("busy straight after reset");

endmodule

bind hsv_to_led_pulse_encoder hsvle_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_pulse_word  (rsp_pulse_word),
   .rsp_last_of_led (rsp_last_of_led)
);
